/* design/tcce_pkg.sv */
// Shared types and constants for the text console character engine.
// Used by the address unit, the cell memory, the sequencer and the top level.
package tcce_pkg;

	localparam int LINES    = 25;
	localparam int COLUMNS  = 80;
	localparam int NCELLS   = LINES * COLUMNS;
	localparam int ADDR_W   = $clog2(NCELLS);
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int CODE_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = CODE_W + ATTR_W;

	localparam logic [ATTR_W-1:0] RESET_COLOR = 8'd10;
	localparam logic [CODE_W-1:0] CODE_LF     = 8'h0A;
	localparam logic [CODE_W-1:0] CODE_CR     = 8'h0D;
	localparam logic [CODE_W-1:0] CODE_BS     = 8'h08;
	localparam logic [CODE_W-1:0] CODE_BLANK  = 8'h00;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_READ  = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_CLEAR,
		S_COPY,
		S_DRAIN,
		S_FILL,
		S_STORE,
		S_DONE
	} state_t;

	// Cell memory write and read request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// One result item
	typedef struct packed {
		logic              scrolled;
		logic [ATTR_W-1:0] cell_attr;
		logic [CODE_W-1:0] cell_char;
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_line;
	} result_t;

endpackage

/* design/tcce_addr_unit.sv */
// Cell address unit: maps a (line, column) position to a linear cell index.
// Depends on tcce_pkg for the screen geometry.
module tcce_addr_unit (
	input  logic [tcce_pkg::ROW_W-1:0]  row,
	input  logic [tcce_pkg::COL_W-1:0]  column,
	output logic [tcce_pkg::ADDR_W-1:0] addr
);
	import tcce_pkg::*;

	// Multiply by the line length and add the column
	assign addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(column);

endmodule

/* design/tcce_cell_ram.sv */
// Screen cell memory: one write port and one registered read port.
// Depends on tcce_pkg for the depth, widths and request struct.
module tcce_cell_ram (
	input  logic                        clk,
	input  tcce_pkg::mem_req_t          req,
	output logic [tcce_pkg::CELL_W-1:0] rdata
);
	import tcce_pkg::*;

	logic [CELL_W-1:0] mem_q [NCELLS];
	logic [CELL_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Read port, data registered
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/tcce_seq.sv */
// Sequencer for the console engine: cursor state, action decode, scroll and
// clear sweeps over the cell memory, and the result register.
// Depends on tcce_pkg; drives tcce_addr_unit and tcce_cell_ram from the top.
module tcce_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  tcce_pkg::act_t              action,
	input  logic [tcce_pkg::CODE_W-1:0] char_code,
	input  logic [tcce_pkg::ROW_W-1:0]  row,
	input  logic [tcce_pkg::COL_W-1:0]  column,
	input  logic [tcce_pkg::ATTR_W-1:0] text_color,
	output logic [tcce_pkg::ROW_W-1:0]  au_row,
	output logic [tcce_pkg::COL_W-1:0]  au_column,
	input  logic [tcce_pkg::ADDR_W-1:0] au_addr,
	output tcce_pkg::mem_req_t          mem_req,
	input  logic [tcce_pkg::CELL_W-1:0] rdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tcce_pkg::result_t           result
);
	import tcce_pkg::*;

	localparam logic [ROW_W-1:0]  LAST_LINE  = ROW_W'(LINES - 1);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
	localparam logic [COL_W-1:0]  WRAP_COL   = COL_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(NCELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(NCELLS - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] LINE_LEN   = ADDR_W'(COLUMNS);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              pend_q, pend_d;
	logic [ADDR_W-1:0] wa_q, wa_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic              sc_q, sc_d;
	logic              store_pend_q, store_pend_d;
	logic              rd_ok_q, rd_ok_d;
	logic              out_valid_q, out_valid_d;
	act_t              act_q, act_d;
	logic [CODE_W-1:0] code_q, code_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	result_t           res_q, res_d;
	logic [CELL_W-1:0] blank_cell;
	logic              pos_ok;

	assign blank_cell = {text_color, CODE_BLANK};
	assign pos_ok     = (row_q < ROW_W'(LINES)) && (col_q < WRAP_COL);
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign result     = res_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			sc_q         <= 1'b0;
			store_pend_q <= 1'b0;
			rd_ok_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			pend_q       <= pend_d;
			cur_row_q    <= cur_row_d;
			cur_col_q    <= cur_col_d;
			sc_q         <= sc_d;
			store_pend_q <= store_pend_d;
			rd_ok_q      <= rd_ok_d;
			out_valid_q  <= out_valid_d;
		end
	end

	// Request fields and result payload
	always_ff @(posedge clk) begin
		act_q  <= act_d;
		code_q <= code_d;
		row_q  <= row_d;
		col_q  <= col_d;
		wa_q   <= wa_d;
		res_q  <= res_d;
	end

	// Next state, memory requests and cursor updates
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		pend_d       = pend_q;
		wa_d         = wa_q;
		cur_row_d    = cur_row_q;
		cur_col_d    = cur_col_q;
		sc_d         = sc_q;
		store_pend_d = store_pend_q;
		rd_ok_d      = rd_ok_q;
		act_d        = act_q;
		code_d       = code_q;
		row_d        = row_q;
		col_d        = col_q;
		res_d        = res_q;
		au_row       = row_q;
		au_column    = col_q;
		mem_req      = '0;
		out_valid_d  = out_valid_q && !out_ready;

		case (state_q)
			// Fill every cell with blank and the reset color
			S_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				mem_req.wdata = {RESET_COLOR, CODE_BLANK};
				idx_d         = idx_q + 1'b1;
				if (idx_q == LAST_CELL) begin
					idx_d   = '0;
					state_d = S_IDLE;
				end
			end

			// Take a request
			S_IDLE: begin
				if (in_valid) begin
					act_d        = action;
					code_d       = char_code;
					row_d        = row;
					col_d        = column;
					sc_d         = 1'b0;
					store_pend_d = 1'b0;
					rd_ok_d      = 1'b0;
					state_d      = S_EXEC;
				end
			end

			// Decode the action
			S_EXEC: begin
				state_d = S_DONE;
				case (act_q)
					ACT_PUT: begin
						if (code_q inside {CODE_LF, CODE_CR}) begin
							cur_col_d = '0;
							if (cur_row_q == LAST_LINE) begin
								sc_d    = 1'b1;
								idx_d   = '0;
								pend_d  = 1'b0;
								state_d = S_COPY;
							end else begin
								cur_row_d = cur_row_q + 1'b1;
							end
						end else if (code_q == CODE_BS) begin
							// Erase the previous cell, back to the line above
							if (cur_col_q != '0) begin
								cur_col_d     = cur_col_q - 1'b1;
								au_row        = cur_row_q;
								au_column     = cur_col_q - 1'b1;
								mem_req.we    = 1'b1;
								mem_req.waddr = au_addr;
								mem_req.wdata = blank_cell;
							end else if (cur_row_q != '0) begin
								cur_row_d     = cur_row_q - 1'b1;
								cur_col_d     = LAST_COL;
								au_row        = cur_row_q - 1'b1;
								au_column     = LAST_COL;
								mem_req.we    = 1'b1;
								mem_req.waddr = au_addr;
								mem_req.wdata = blank_cell;
							end
						end else if (cur_col_q >= WRAP_COL) begin
							// Deferred wrap, with a scroll at the bottom
							if (cur_row_q == LAST_LINE) begin
								cur_col_d    = '0;
								sc_d         = 1'b1;
								store_pend_d = 1'b1;
								idx_d        = '0;
								pend_d       = 1'b0;
								state_d      = S_COPY;
							end else begin
								cur_row_d     = cur_row_q + 1'b1;
								cur_col_d     = COL_W'(1);
								au_row        = cur_row_q + 1'b1;
								au_column     = '0;
								mem_req.we    = 1'b1;
								mem_req.waddr = au_addr;
								mem_req.wdata = {text_color, code_q};
							end
						end else begin
							cur_col_d     = cur_col_q + 1'b1;
							au_row        = cur_row_q;
							au_column     = cur_col_q;
							mem_req.we    = 1'b1;
							mem_req.waddr = au_addr;
							mem_req.wdata = {text_color, code_q};
						end
					end
					ACT_CLEAR: begin
						cur_row_d = '0;
						cur_col_d = '0;
						idx_d     = '0;
						state_d   = S_CLEAR;
					end
					ACT_WRITE: begin
						mem_req.we    = pos_ok;
						mem_req.waddr = au_addr;
						mem_req.wdata = {text_color, code_q};
					end
					ACT_READ: begin
						mem_req.re    = pos_ok;
						mem_req.raddr = au_addr;
						rd_ok_d       = pos_ok;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			// Blank the whole screen
			S_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				mem_req.wdata = blank_cell;
				idx_d         = idx_q + 1'b1;
				if (idx_q == LAST_CELL) begin
					state_d = S_DONE;
				end
			end

			// Move each cell up one line: read ahead, write it in the following cycle
			S_COPY: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = idx_q + LINE_LEN;
				mem_req.we    = pend_q;
				mem_req.waddr = wa_q;
				mem_req.wdata = rdata;
				pend_d        = 1'b1;
				wa_d          = idx_q;
				idx_d         = idx_q + 1'b1;
				if (idx_q == LAST_COPY) begin
					state_d = S_DRAIN;
				end
			end

			// Write the last copied cell
			S_DRAIN: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = wa_q;
				mem_req.wdata = rdata;
				pend_d        = 1'b0;
				state_d       = S_FILL;
			end

			// Blank the bottom line
			S_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				mem_req.wdata = blank_cell;
				idx_d         = idx_q + 1'b1;
				if (idx_q == LAST_CELL) begin
					state_d = store_pend_q ? S_STORE : S_DONE;
				end
			end

			// Store the character that caused the scroll
			S_STORE: begin
				au_row        = cur_row_q;
				au_column     = cur_col_q;
				mem_req.we    = 1'b1;
				mem_req.waddr = au_addr;
				mem_req.wdata = {text_color, code_q};
				cur_col_d     = cur_col_q + 1'b1;
				state_d       = S_DONE;
			end

			// Hand the result over once the output register is free
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					res_d.cursor_line   = cur_row_q;
					res_d.cursor_column = cur_col_q;
					res_d.cell_char     = rd_ok_q ? rdata[CODE_W-1:0] : '0;
					res_d.cell_attr     = rd_ok_q ? rdata[CELL_W-1:CODE_W] : '0;
					res_d.scrolled      = sc_q;
					out_valid_d         = 1'b1;
					state_d             = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/text_console_char_engine.sv */
// Text console character engine: a 25 x 80 screen of code/attribute cells
// and a cursor, driven by put, clear, positioned write and read requests.
//
// Requests enter on the s_ stream (action in s_tuser, the other fields in
// s_tdata); one result per request leaves on the m_ stream. The attribute
// register is written over the cfg channel, which is always ready.
// A put, positioned write or read passes the execute and done states before
// its result is valid, and the input stays busy until the sequencer is idle
// again, so such a request is not taken before the last one is done. Clear
// and scroll both sweep the single-write-port cell memory one cell per cycle,
// scroll copying with a registered read ahead.
// One request is worked on at a time; s_tready is high only while idle.
// A result waiting in the output register does not stop the next request
// from being taken; the sequencer holds its result until m_tready frees it.
// After reset the memory is swept once, writing code 0 with
// attribute 10 into every cell; no request is taken during that pass, but
// configuration writes are. Reset also homes the cursor and sets the
// attribute register to 10.
module text_console_char_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], row[12:8], column[19:13], zero fill
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cursor_line[4:0], cursor_column[11:5],
	                               // cell_char[19:12], cell_attr[27:20], scrolled[28]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // text_color[7:0]
);
	import tcce_pkg::*;

	logic [ATTR_W-1:0] text_color_q;
	logic [ROW_W-1:0]  au_row;
	logic [COL_W-1:0]  au_column;
	logic [ADDR_W-1:0] au_addr;
	mem_req_t          mem_req;
	logic [CELL_W-1:0] rdata;
	result_t           result;

	// Attribute register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	tcce_addr_unit u_addr (
		.row    (au_row),
		.column (au_column),
		.addr   (au_addr)
	);

	tcce_cell_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	tcce_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (act_t'(s_tuser)),
		.char_code  (s_tdata[7:0]),
		.row        (s_tdata[12:8]),
		.column     (s_tdata[19:13]),
		.text_color (text_color_q),
		.au_row     (au_row),
		.au_column  (au_column),
		.au_addr    (au_addr),
		.mem_req    (mem_req),
		.rdata      (rdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.result     (result)
	);

	// Pack the result, zero fill to whole bytes
	assign m_tdata = {3'b000, result};

`ifndef SYNTHESIS
	// The cursor column never passes the wrap-pending position
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:5] <= COL_W'(COLUMNS)))
		else $error("cursor column beyond wrap position");

	// A scroll always leaves the cursor on the bottom line
	a_scroll_line: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[28]) |-> (m_tdata[4:0] == ROW_W'(LINES - 1)))
		else $error("scroll without cursor on bottom line");

	// The cell memory is never written while waiting for a request
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mem_req.we)
		else $error("cell write while idle");
`endif

endmodule

/* test/tcce_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for text_console_char_engine: follows the request, color and
// result streams, predicts each result from its own copy of the screen and compares.
// Depends on tcce_pkg for the screen size, the action codes and the result layout.
module tcce_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], row[12:8], column[19:13], zero fill
	input  logic [1:0]  s_tuser,   // action[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // cursor_line[4:0], cursor_column[11:5],
	                               // cell_char[19:12], cell_attr[27:20], scrolled[28]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,  // text_color[7:0]
	output int          mismatches,
	output int          pending_results
);
	import tcce_pkg::*;

	// Shadow screen, cursor and attribute
	logic [CELL_W-1:0] cells [NCELLS];
	logic [ATTR_W-1:0] ink_attr;
	int                cur_row;
	int                cur_col;

	// Predicted results, oldest first
	result_t due_q[$];
	result_t seen;
	result_t want;
	int      miss_count = 0;

	assign mismatches = miss_count;

	task automatic report_error(input string what, input int got, input int exp_val);
		miss_count++;
		$display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	function automatic void wipe_screen();
		for (int i = 0; i < NCELLS; i++)
			cells[i] = {ink_attr, CODE_BLANK};
		cur_row = 0;
		cur_col = 0;
	endfunction

	// Move every line up one and blank the bottom line
	function automatic void scroll_screen();
		for (int i = 0; i < NCELLS - COLUMNS; i++)
			cells[i] = cells[i + COLUMNS];
		for (int i = NCELLS - COLUMNS; i < NCELLS; i++)
			cells[i] = {ink_attr, CODE_BLANK};
	endfunction

	// Drop writes outside the screen
	function automatic void store_cell(input int r, input int c, input logic [CODE_W-1:0] code);
		if (r < LINES && c < COLUMNS)
			cells[r * COLUMNS + c] = {ink_attr, code};
	endfunction

	// Apply one request to the shadow state and return the result it yields
	function automatic result_t console_apply(input act_t act, input logic [CODE_W-1:0] code,
			input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		result_t res;
		res = '0;
		case (act)
			ACT_PUT: begin
				if (code == CODE_LF || code == CODE_CR) begin
					cur_col = 0;
					if (cur_row + 1 >= LINES) begin
						cur_row = LINES - 1;
						scroll_screen();
						res.scrolled = 1'b1;
					end else begin
						cur_row++;
					end
				end else if (code == CODE_BS) begin
					// erase the previous cell; at home do nothing
					if (cur_col > 0) begin
						cur_col--;
						store_cell(cur_row, cur_col, CODE_BLANK);
					end else if (cur_row > 0) begin
						cur_row--;
						cur_col = COLUMNS - 1;
						store_cell(cur_row, cur_col, CODE_BLANK);
					end
				end else begin
					// take a pending wrap first, then scroll if past the bottom
					if (cur_col >= COLUMNS) begin
						cur_row++;
						cur_col = 0;
					end
					if (cur_row >= LINES) begin
						cur_row = LINES - 1;
						scroll_screen();
						res.scrolled = 1'b1;
					end
					store_cell(cur_row, cur_col, code);
					cur_col++;
				end
			end
			ACT_CLEAR: begin
				wipe_screen();
			end
			ACT_WRITE: begin
				store_cell(int'(r), int'(c), code);
			end
			default: begin
				if (r < LINES && c < COLUMNS) begin
					res.cell_char = cells[r * COLUMNS + c][CODE_W-1:0];
					res.cell_attr = cells[r * COLUMNS + c][CELL_W-1:CODE_W];
				end
			end
		endcase
		res.cursor_line   = cur_row[ROW_W-1:0];
		res.cursor_column = cur_col[COL_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_attr = RESET_COLOR;
			wipe_screen();
			due_q.delete();
			pending_results <= 0;
		end else begin
			// compare an accepted result with the oldest prediction
			if (m_tvalid && m_tready) begin
				seen = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (due_q.size() == 0) begin
					report_error("result with no request waiting", int'(m_tdata), 0);
				end else begin
					want = due_q.pop_front();
					if (seen.cursor_line !== want.cursor_line)
						report_error("cursor_line", int'(seen.cursor_line),
								int'(want.cursor_line));
					if (seen.cursor_column !== want.cursor_column)
						report_error("cursor_column", int'(seen.cursor_column),
								int'(want.cursor_column));
					if (seen.cell_char !== want.cell_char)
						report_error("cell_char", int'(seen.cell_char), int'(want.cell_char));
					if (seen.cell_attr !== want.cell_attr)
						report_error("cell_attr", int'(seen.cell_attr), int'(want.cell_attr));
					if (seen.scrolled !== want.scrolled)
						report_error("scrolled", int'(seen.scrolled), int'(want.scrolled));
				end
			end
			// latch a new attribute
			if (cfg_valid && cfg_ready)
				ink_attr = cfg_data;
			// predict the result of an accepted request
			if (s_tvalid && s_tready)
				due_q.push_back(console_apply(act_t'(s_tuser), s_tdata[7:0], s_tdata[12:8],
						s_tdata[19:13]));
			pending_results <= due_q.size();
		end
	end

endmodule

/* test/tb_text_console_char_engine.sv */
`timescale 1ns / 1ps
// Testbench top for text_console_char_engine: generates requests and attribute
// writes, paces both streams and gives the verdict. Depends on tcce_pkg, the
// engine RTL and tcce_result_checker, which does the prediction and comparison.
module tb_text_console_char_engine;
	import tcce_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int RECV_HOLD   = 500;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;    // char_code[7:0], row[12:8], column[19:13], zero fill
	logic [1:0]  s_tuser = '0;    // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // cursor_line[4:0], cursor_column[11:5],
	                              // cell_char[19:12], cell_attr[27:20], scrolled[28]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;   // text_color[7:0]

	int   send_idle_pct = 31;
	int   recv_idle_pct = 67;
	logic stall_burst = 1'b0;
	logic burst_taken = 1'b0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   issued = 0;
	int   mismatches;
	int   pending_results;

	text_console_char_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	tcce_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	always #6 clk = ~clk;

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_text_console_char_engine NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: one long hold-off on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_burst && !burst_taken) begin
			m_tready    <= 1'b0;
			hold_left   <= RECV_HOLD;
			burst_taken <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Offer one request after a random gap and hold it until accepted
	task automatic offer_request(input act_t act, input logic [7:0] code,
			input logic [4:0] r, input logic [6:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0000, c, r, code};
		do @(posedge clk); while (!s_tready);
		issued++;
	endtask

	// Stop offering and wait for every predicted result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	task automatic write_color(input logic [7:0] attr);
		cfg_valid <= 1'b1;
		cfg_data  <= attr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] plain_code();
		logic [7:0] code;
		do
			code = 8'($urandom_range(0, 255));
		while (code == CODE_LF || code == CODE_CR || code == CODE_BS);
		return code;
	endfunction

	// Bursts of text, backspaces and cell accesses, with occasional clears and some raw noise
	task automatic random_segment(input int count);
		int stop_at, kind, len;
		stop_at = issued + count;
		while (issued < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 20);
				repeat (len)
					offer_request(ACT_PUT, plain_code(), 5'($urandom_range(0, 31)),
							7'($urandom_range(0, 127)));
				if ($urandom_range(0, 1))
					offer_request(ACT_PUT, $urandom_range(0, 1) ? CODE_LF : CODE_CR,
							5'd0, 7'd0);
			end else if (kind < 52) begin
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 5);
				repeat (len)
					offer_request(ACT_PUT, CODE_BS, 5'($urandom_range(0, 31)),
							7'($urandom_range(0, 127)));
			end else if (kind < 82) begin
				repeat ($urandom_range(1, 8))
					offer_request($urandom_range(0, 1) ? ACT_WRITE : ACT_READ,
							8'($urandom_range(0, 255)),
							5'(($urandom_range(0, 99) < 88) ? $urandom_range(0, LINES - 1)
									: $urandom_range(LINES, 31)),
							7'(($urandom_range(0, 99) < 88) ? $urandom_range(0, COLUMNS - 1)
									: $urandom_range(COLUMNS, 127)));
			end else if (kind < 84) begin
				offer_request(ACT_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
						7'($urandom_range(0, 127)));
			end else begin
				offer_request(act_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, range edges, backspace corners, clear
		offer_request(ACT_READ,  8'h00, 5'd0,  7'd0);
		offer_request(ACT_WRITE, 8'hFF, 5'd24, 7'd79);
		offer_request(ACT_READ,  8'h00, 5'd24, 7'd79);
		offer_request(ACT_WRITE, 8'h41, 5'd25, 7'd0);
		offer_request(ACT_WRITE, 8'h42, 5'd0,  7'd80);
		offer_request(ACT_WRITE, 8'h43, 5'd31, 7'd127);
		offer_request(ACT_READ,  8'h00, 5'd31, 7'd127);
		offer_request(ACT_READ,  8'h00, 5'd0,  7'd80);
		offer_request(ACT_WRITE, 8'h00, 5'd0,  7'd1);
		offer_request(ACT_READ,  8'h00, 5'd0,  7'd1);
		offer_request(ACT_PUT,   CODE_BS, 5'd0, 7'd0);
		offer_request(ACT_PUT,   8'h41, 5'd0, 7'd0);
		offer_request(ACT_PUT,   CODE_BS, 5'd0, 7'd0);
		offer_request(ACT_PUT,   CODE_CR, 5'd0, 7'd0);
		offer_request(ACT_PUT,   CODE_LF, 5'd0, 7'd0);
		offer_request(ACT_PUT,   CODE_BS, 5'd0, 7'd0);
		offer_request(ACT_READ,  8'h00, 5'd1,  7'd79);
		offer_request(ACT_CLEAR, 8'h00, 5'd0,  7'd0);
		offer_request(ACT_READ,  8'h00, 5'd24, 7'd79);
		offer_request(ACT_PUT,   8'hFF, 5'd0, 7'd0);
		offer_request(ACT_PUT,   8'h00, 5'd0, 7'd0);
		offer_request(ACT_READ,  8'h00, 5'd0,  7'd1);
		drain_results();
		write_color(8'hFF);

		// Fill a line to a pending wrap, erase under it, wrap, then scroll
		offer_request(ACT_PUT, CODE_LF, 5'd0, 7'd0);
		repeat (COLUMNS)
			offer_request(ACT_PUT, plain_code(), 5'd0, 7'd0);
		offer_request(ACT_PUT, CODE_BS, 5'd0, 7'd0);
		offer_request(ACT_PUT, plain_code(), 5'd0, 7'd0);
		offer_request(ACT_PUT, plain_code(), 5'd0, 7'd0);
		repeat (30)
			offer_request(ACT_PUT, CODE_LF, 5'd0, 7'd0);
		random_segment(190);
		drain_results();
		write_color(8'h00);

		// Swap idling and hold the result side off once to back up the input
		send_idle_pct <= 67;
		recv_idle_pct <= 31;
		stall_burst   <= 1'b1;
		random_segment(250);
		drain_results();
		write_color(8'($urandom_range(0, 255)));
		random_segment(250);
		drain_results();
		write_color(8'($urandom_range(1, 254)));

		// Full rate on both sides
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		random_segment(250);
		drain_results();
		write_color(8'h81);
		random_segment(250);
		drain_results();

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_text_console_char_engine OK");
		end else begin
			$display("tb_text_console_char_engine NOT OK");
		end
		$finish;
	end

endmodule
